FILE: rtl/core/met_pkg.sv
// package for the mandelbrot escape-time unit: number format, register
// indexes, configuration, point and queue status structs used across the modules
// no dependencies
package met_pkg;

    // signed Q3.28 coordinates, Q4.28 in the 32-bit working words
    localparam int FRAC_BITS = 28;
    localparam int WORD_W    = 32;
    localparam int COORD_W   = 31;
    localparam int PIX_CNT_W = 13;
    localparam int PIXEL_W   = 12;
    localparam int COUNT_W   = 16;
    localparam int PROD_W    = 2 * WORD_W;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = COORD_W;

    // stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // escape bound 4.0 with 28 fraction bits, held at product width
    localparam logic signed [PROD_W-1:0] ESCAPE_BOUND = PROD_W'(64'sd4 <<< FRAC_BITS);

    // register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_UPPER_X    = 3'd0,
        REG_UPPER_Y    = 3'd1,
        REG_LOWER_X    = 3'd2,
        REG_LOWER_Y    = 3'd3,
        REG_PIXELS_W   = 3'd4,
        REG_PIXELS_T   = 3'd5,
        REG_ITER_LIMIT = 3'd6
    } t_reg_idx;

    // reset values of the registers
    localparam logic signed [COORD_W-1:0] RST_UPPER_X    = -31'sd536870912;
    localparam logic signed [COORD_W-1:0] RST_UPPER_Y    = 31'sd268435456;
    localparam logic signed [COORD_W-1:0] RST_LOWER_X    = 31'sd268435456;
    localparam logic signed [COORD_W-1:0] RST_LOWER_Y    = -31'sd268435456;
    localparam logic [PIX_CNT_W-1:0]      RST_PIXELS     = 13'd256;
    localparam logic [COUNT_W-1:0]        RST_ITER_LIMIT = 16'd255;

    // configuration register file contents
    typedef struct packed {
        logic signed [COORD_W-1:0] upper_x;
        logic signed [COORD_W-1:0] upper_y;
        logic signed [COORD_W-1:0] lower_x;
        logic signed [COORD_W-1:0] lower_y;
        logic [PIX_CNT_W-1:0]      pixels_wide;
        logic [PIX_CNT_W-1:0]      pixels_tall;
        logic [COUNT_W-1:0]        iteration_limit;
    } t_cfg;

    // one point c of the complex plane
    typedef struct packed {
        logic signed [WORD_W-1:0] cx;
        logic signed [WORD_W-1:0] cy;
    } t_point;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

FILE: rtl/core/mandelbrot_escape_time_unit.sv
// mandelbrot escape-time unit: one pixel item in, one escape count out.
// the step division runs on the first item after reset or after a write to a tile
// register; the front can take further items while the back part iterates, and
// the item rate is set by the multiply / update loop of the iteration back part,
// which ends an item when the limit is reached or the point escapes.
// reset: synchronous, clears all control and loads the register defaults.
module mandelbrot_escape_time_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [met_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [met_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // pixel items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [met_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // column[11:0], row[23:12]
    // escape counts
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [met_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // escape_count[15:0]
);
    import met_pkg::*;

    t_cfg        r_cfg;
    logic        w_steps_stale;
    logic        w_push, w_pop;
    t_point      w_push_point, w_pop_point;
    t_queue_stat w_queue_stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.upper_x         <= RST_UPPER_X;
            r_cfg.upper_y         <= RST_UPPER_Y;
            r_cfg.lower_x         <= RST_LOWER_X;
            r_cfg.lower_y         <= RST_LOWER_Y;
            r_cfg.pixels_wide     <= RST_PIXELS;
            r_cfg.pixels_tall     <= RST_PIXELS;
            r_cfg.iteration_limit <= RST_ITER_LIMIT;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_UPPER_X:    r_cfg.upper_x         <= i_cfg_data;
                REG_UPPER_Y:    r_cfg.upper_y         <= i_cfg_data;
                REG_LOWER_X:    r_cfg.lower_x         <= i_cfg_data;
                REG_LOWER_Y:    r_cfg.lower_y         <= i_cfg_data;
                REG_PIXELS_W:   r_cfg.pixels_wide     <= i_cfg_data[PIX_CNT_W-1:0];
                REG_PIXELS_T:   r_cfg.pixels_tall     <= i_cfg_data[PIX_CNT_W-1:0];
                REG_ITER_LIMIT: r_cfg.iteration_limit <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // a write to a tile register invalidates the stored steps
    assign w_steps_stale = i_cfg_we && (i_cfg_addr inside {REG_UPPER_X, REG_UPPER_Y,
                           REG_LOWER_X, REG_LOWER_Y, REG_PIXELS_W, REG_PIXELS_T});

    met_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_steps_stale (w_steps_stale),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_column      (s_axis_tdata[PIXEL_W-1:0]),
        .i_row         (s_axis_tdata[2*PIXEL_W-1:PIXEL_W]),
        .i_queue_stat  (w_queue_stat),
        .o_push        (w_push),
        .o_point       (w_push_point)
    );

    met_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_point (w_push_point),
        .i_pop   (w_pop),
        .o_point (w_pop_point),
        .o_stat  (w_queue_stat)
    );

    met_iter u_iter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_limit      (r_cfg.iteration_limit),
        .i_queue_stat (w_queue_stat),
        .i_point      (w_pop_point),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_count      (m_axis_tdata)
    );

endmodule

FILE: rtl/core/met_front.sv
// front part: accepts pixel items, derives the pixel steps with a
// bit-serial divider and maps the pixel to a point c; uses met_pkg
module met_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  met_pkg::t_cfg                 i_cfg,
    input  logic                          i_steps_stale,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [met_pkg::PIXEL_W-1:0]   i_column,
    input  logic [met_pkg::PIXEL_W-1:0]   i_row,
    input  met_pkg::t_queue_stat          i_queue_stat,
    output logic                          o_push,
    output met_pkg::t_point               o_point
);
    import met_pkg::*;

    localparam int DIV_CNT_W = $clog2(WORD_W);

    typedef enum logic [4:0] {
        F_IDLE   = 5'b00001,
        F_DSETUP = 5'b00010,
        F_DIV    = 5'b00100,
        F_MUL    = 5'b01000,
        F_PUSH   = 5'b10000
    } t_front_state;

    t_front_state r_state, n_state;

    logic [PIXEL_W-1:0]   r_col, r_row;
    logic                 r_steps_ok;
    logic [WORD_W-1:0]    r_step_x, r_step_y;
    logic                 r_div_sel;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [PIX_CNT_W-1:0] r_div_rem;
    logic [PIX_CNT_W-1:0] r_div_d;
    logic [WORD_W-1:0]    r_div_quo;
    logic                 r_div_neg;
    logic [WORD_W-1:0]    r_prod_x, r_prod_y;

    // dividend and divisor for the step being set up
    logic signed [WORD_W-1:0] w_diff;
    logic [PIX_CNT_W-1:0]     w_pix;
    always_comb begin
        if (r_div_sel) begin
            w_diff = WORD_W'(i_cfg.upper_y) - WORD_W'(i_cfg.lower_y);
            w_pix  = i_cfg.pixels_tall;
        end else begin
            w_diff = WORD_W'(i_cfg.lower_x) - WORD_W'(i_cfg.upper_x);
            w_pix  = i_cfg.pixels_wide;
        end
    end

    // one restoring division step
    logic [PIX_CNT_W:0]   w_trial;
    logic                 w_fit;
    logic [WORD_W-1:0]    w_quo_next;
    logic [WORD_W-1:0]    w_step;
    always_comb begin
        w_trial    = {r_div_rem, r_div_quo[WORD_W-1]};
        w_fit      = w_trial >= {1'b0, r_div_d};
        w_quo_next = {r_div_quo[WORD_W-2:0], w_fit};
        w_step     = r_div_neg ? (WORD_W'(0) - w_quo_next) : w_quo_next;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_valid) n_state = r_steps_ok ? F_MUL : F_DSETUP;
            end
            F_DSETUP: n_state = F_DIV;
            F_DIV: begin
                if (r_div_cnt == DIV_CNT_W'(WORD_W - 1)) n_state = r_div_sel ? F_MUL : F_DSETUP;
            end
            F_MUL: n_state = F_PUSH;
            F_PUSH: begin
                if (!i_queue_stat.full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_steps_ok <= 1'b0;
            r_div_sel  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == F_DIV && r_div_cnt == DIV_CNT_W'(WORD_W - 1)) begin
                r_div_sel <= ~r_div_sel;
                if (r_div_sel) r_steps_ok <= 1'b1;
            end
            if (i_steps_stale) begin
                r_steps_ok <= 1'b0;
                r_div_sel  <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_col <= i_column;
                r_row <= i_row;
            end
            F_DSETUP: begin
                r_div_neg <= w_diff[WORD_W-1];
                r_div_quo <= w_diff[WORD_W-1] ? (WORD_W'(0) - w_diff) : w_diff;
                r_div_d   <= (w_pix == '0) ? PIX_CNT_W'(1) : w_pix;
                r_div_rem <= '0;
                r_div_cnt <= '0;
            end
            F_DIV: begin
                r_div_rem <= w_fit ? PIX_CNT_W'(w_trial - {1'b0, r_div_d})
                                   : w_trial[PIX_CNT_W-1:0];
                r_div_quo <= w_quo_next;
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                if (r_div_cnt == DIV_CNT_W'(WORD_W - 1)) begin
                    if (r_div_sel) r_step_y <= w_step;
                    else           r_step_x <= w_step;
                end
            end
            F_MUL: begin
                // low word of pixel times step is all that survives the wrap
                r_prod_x <= {{(WORD_W-PIXEL_W){1'b0}}, r_col} * r_step_x;
                r_prod_y <= {{(WORD_W-PIXEL_W){1'b0}}, r_row} * r_step_y;
            end
            default: ;
        endcase
    end

    // point of the pixel, handed to the queue
    always_comb begin
        o_point.cx = WORD_W'(i_cfg.upper_x) + r_prod_x;
        o_point.cy = WORD_W'(i_cfg.upper_y) - r_prod_y;
    end

    assign o_push  = (r_state == F_PUSH) && !i_queue_stat.full;
    assign o_ready = (r_state == F_IDLE);

endmodule

FILE: rtl/core/met_queue.sv
// short queue of points between the front and the iteration back part
// uses met_pkg for the point type and depth
module met_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  met_pkg::t_point       i_point,
    input  logic                  i_pop,
    output met_pkg::t_point       o_point,
    output met_pkg::t_queue_stat  o_stat
);
    import met_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_point           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop)      r_count <= r_count + CNT_W'(1);
            else if (i_pop && !i_push) r_count <= r_count - CNT_W'(1);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_point;
    end

    assign o_point      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

FILE: rtl/core/met_iter.sv
// back part: iterates z <- z*z + c for one point at a time and holds
// the escape count in an output register; uses met_pkg
module met_iter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [met_pkg::COUNT_W-1:0]   i_limit,
    input  met_pkg::t_queue_stat          i_queue_stat,
    input  met_pkg::t_point               i_point,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [met_pkg::COUNT_W-1:0]   o_count
);
    import met_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL  = 4'b0010,
        B_UPD  = 4'b0100,
        B_OUT  = 4'b1000
    } t_back_state;

    t_back_state r_state, n_state;

    logic signed [WORD_W-1:0] r_cx, r_cy, r_x, r_y;
    logic signed [PROD_W-1:0] r_pxx, r_pyy, r_pxy;
    logic [COUNT_W-1:0]       r_n;
    logic [COUNT_W-1:0]       r_res;
    logic                     r_res_valid;

    // floored squares, escape test and next z
    logic signed [PROD_W-1:0] w_xx, w_yy, w_xy2, w_mag;
    logic                     w_escape;
    logic [WORD_W-1:0]        w_nx, w_ny;
    always_comb begin
        w_xx     = r_pxx >>> FRAC_BITS;
        w_yy     = r_pyy >>> FRAC_BITS;
        w_xy2    = r_pxy >>> (FRAC_BITS - 1);
        w_mag    = w_xx + w_yy;
        w_escape = (w_mag >= ESCAPE_BOUND);
        w_nx     = w_xx[WORD_W-1:0] - w_yy[WORD_W-1:0] + r_cx;
        w_ny     = w_xy2[WORD_W-1:0] + r_cy;
    end

    logic w_out_free;
    assign w_out_free = !r_res_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_queue_stat.empty) n_state = B_MUL;
            end
            B_MUL:  n_state = (r_n >= i_limit) ? B_OUT : B_UPD;
            B_UPD:  n_state = w_escape ? B_OUT : B_MUL;
            B_OUT: begin
                if (w_out_free) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // control and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_OUT && w_out_free) r_res_valid <= 1'b1;
            else if (i_ready)                   r_res_valid <= 1'b0;
        end
    end

    // iteration datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_cx <= i_point.cx;
                r_cy <= i_point.cy;
                r_x  <= i_point.cx;
                r_y  <= i_point.cy;
                r_n  <= '0;
            end
            B_MUL: begin
                r_pxx <= r_x * r_x;
                r_pyy <= r_y * r_y;
                r_pxy <= r_x * r_y;
            end
            B_UPD: begin
                if (!w_escape) begin
                    r_x <= w_nx;
                    r_y <= w_ny;
                    r_n <= r_n + COUNT_W'(1);
                end
            end
            B_OUT: begin
                if (w_out_free) r_res <= r_n;
            end
            default: ;
        endcase
    end

    assign o_pop   = (r_state == B_IDLE) && !i_queue_stat.empty;
    assign o_valid = r_res_valid;
    assign o_count = r_res;

endmodule

FILE: rtl/core/met_checker.sv
// port-level checks for the mandelbrot escape-time unit, bound to the top
// level; uses met_pkg for widths and the iteration limit default
module met_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [met_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [met_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [met_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import met_pkg::*;

    // at most front, queue, back and output register hold items
    localparam int MAX_OUTSTANDING = QUEUE_DEPTH + 3;

    logic [3:0]         r_outstanding;
    logic [COUNT_W-1:0] r_limit;
    logic               w_in_acc, w_out_acc;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    // items in flight and a shadow of the iteration limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
            r_limit       <= RST_ITER_LIMIT;
        end else begin
            if (w_in_acc && !w_out_acc)      r_outstanding <= r_outstanding + 4'd1;
            else if (w_out_acc && !w_in_acc) r_outstanding <= r_outstanding - 4'd1;
            if (i_cfg_we && t_reg_idx'(i_cfg_addr) == REG_ITER_LIMIT) begin
                r_limit <= i_cfg_data[COUNT_W-1:0];
            end
        end
    end

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // no result without an item in flight, and never more than the unit holds
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding == 4'd0 |-> !m_axis_tvalid)
        else $error("result without an item");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= 4'(MAX_OUTSTANDING))
        else $error("too many items in flight");

    // a count never passes the iteration limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[COUNT_W-1:0] <= r_limit)
        else $error("escape count above limit");

endmodule

bind mandelbrot_escape_time_unit met_checker u_met_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_addr    (i_cfg_addr),
    .i_cfg_data    (i_cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: bench/mandelbrot_escape_time_checker.sv
// checker for the mandelbrot escape-time unit: watches the register port and
// both item streams, predicts each escape count and compares it on arrival
// depends on met_pkg
module mandelbrot_escape_time_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [met_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [met_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [met_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // column[11:0], row[23:12]
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [met_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // escape_count[15:0]
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import met_pkg::*;

    t_cfg               tile;
    logic [COUNT_W-1:0] counts_due[$];
    int                 fails = 0;

    // escape count of one pixel under the given tile settings
    function automatic logic [COUNT_W-1:0] escape_count_of(t_cfg c, logic [PIXEL_W-1:0] col,
                                                           logic [PIXEL_W-1:0] row);
        longint ux, uy, lx, ly, dw, dt, sx, sy, xx, yy, xy2;
        int     cx, cy, x, y, n;
        ux = $signed(c.upper_x);
        uy = $signed(c.upper_y);
        lx = $signed(c.lower_x);
        ly = $signed(c.lower_y);
        // a pixel count of zero divides as one
        dw = (c.pixels_wide == 0) ? 1 : c.pixels_wide;
        dt = (c.pixels_tall == 0) ? 1 : c.pixels_tall;
        sx = (lx - ux) / dw;
        sy = (uy - ly) / dt;
        cx = int'(ux + longint'(col) * sx);
        cy = int'(uy - longint'(row) * sy);
        x = cx;
        y = cy;
        n = 0;
        // squares are floored, the magnitude test is done wide, updates wrap at 32 bits
        while (n < c.iteration_limit) begin
            xx = (longint'(x) * longint'(x)) >>> FRAC_BITS;
            yy = (longint'(y) * longint'(y)) >>> FRAC_BITS;
            if (xx + yy >= ESCAPE_BOUND) break;
            xy2 = (longint'(x) * longint'(y)) >>> (FRAC_BITS - 1);
            x = int'(xx - yy + cx);
            y = int'(xy2 + cy);
            n++;
        end
        return n[COUNT_W-1:0];
    endfunction

    // register shadow, prediction on each pixel item, compare on each count item
    always @(posedge i_clk) begin
        logic [COUNT_W-1:0] want;
        if (!i_rst_n) begin
            tile.upper_x         = RST_UPPER_X;
            tile.upper_y         = RST_UPPER_Y;
            tile.lower_x         = RST_LOWER_X;
            tile.lower_y         = RST_LOWER_Y;
            tile.pixels_wide     = RST_PIXELS;
            tile.pixels_tall     = RST_PIXELS;
            tile.iteration_limit = RST_ITER_LIMIT;
            counts_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_UPPER_X:    tile.upper_x = i_cfg_data[COORD_W-1:0];
                    REG_UPPER_Y:    tile.upper_y = i_cfg_data[COORD_W-1:0];
                    REG_LOWER_X:    tile.lower_x = i_cfg_data[COORD_W-1:0];
                    REG_LOWER_Y:    tile.lower_y = i_cfg_data[COORD_W-1:0];
                    REG_PIXELS_W:   tile.pixels_wide = i_cfg_data[PIX_CNT_W-1:0];
                    REG_PIXELS_T:   tile.pixels_tall = i_cfg_data[PIX_CNT_W-1:0];
                    REG_ITER_LIMIT: tile.iteration_limit = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                counts_due.push_back(escape_count_of(tile, s_axis_tdata[PIXEL_W-1:0],
                                                     s_axis_tdata[2*PIXEL_W-1:PIXEL_W]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (counts_due.size() == 0) begin
                    $error("escape_count: expected none, actual %0d", m_axis_tdata[COUNT_W-1:0]);
                    fails++;
                end else begin
                    want = counts_due.pop_front();
                    if (want !== m_axis_tdata[COUNT_W-1:0]) begin
                        $error("escape_count: expected %0d, actual %0d", want,
                               m_axis_tdata[COUNT_W-1:0]);
                        fails++;
                    end
                end
            end
        end
        o_pending    = counts_due.size();
        o_fail_count = fails;
    end

endmodule

FILE: bench/mandelbrot_escape_time_unit_test.sv
// top of the mandelbrot escape-time unit bench: clock, reset, register writes,
// pixel items and count back-pressure; the checker gives the verdict count
// depends on met_pkg, mandelbrot_escape_time_unit, mandelbrot_escape_time_checker
module mandelbrot_escape_time_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import met_pkg::*;

    localparam int                  Q_ONE      = 1 << FRAC_BITS;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 31'sh4000_0000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 31'sh3fff_ffff;
    localparam int                  PIXEL_MAX  = (1 << PIXEL_W) - 1;
    localparam int                  ITEM_GOAL  = 1350;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // column[11:0], row[23:12]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // escape_count[15:0]

    int fail_count;
    int pending;
    int pixels_sent = 0;
    bit sender_calm = 1'b0;
    int stall_left = 0;
    int calm_left = 0;

    mandelbrot_escape_time_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mandelbrot_escape_time_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // count receiver: random stalls with calm stretches in between
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 99) < 3)
                calm_left = $urandom_range(50, 300);
            else
                stall_left = pick_gap();
        end
    end

    // one register write, entered and left at a falling edge
    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    // whole tile; the narrow registers get random upper data bits
    task automatic set_tile(logic signed [COORD_W-1:0] ux, logic signed [COORD_W-1:0] uy,
                            logic signed [COORD_W-1:0] lx, logic signed [COORD_W-1:0] ly,
                            logic [PIX_CNT_W-1:0] pw, logic [PIX_CNT_W-1:0] pt,
                            logic [COUNT_W-1:0] lim);
        logic [CFG_DATA_W-1:0] v;
        write_reg(REG_UPPER_X, ux);
        write_reg(REG_UPPER_Y, uy);
        write_reg(REG_LOWER_X, lx);
        write_reg(REG_LOWER_Y, ly);
        v = CFG_DATA_W'($urandom());
        v[PIX_CNT_W-1:0] = pw;
        write_reg(REG_PIXELS_W, v);
        v = CFG_DATA_W'($urandom());
        v[PIX_CNT_W-1:0] = pt;
        write_reg(REG_PIXELS_T, v);
        v = CFG_DATA_W'($urandom());
        v[COUNT_W-1:0] = lim;
        write_reg(REG_ITER_LIMIT, v);
        if ($urandom_range(0, 9) < 3)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
    endtask

    // one pixel item; valid stays high on return so the next item can follow directly
    task automatic push_pixel(int col, int row);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row[PIXEL_W-1:0], col[PIXEL_W-1:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // drop valid and wait until every count is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // random corner coordinate: mostly near the set, sometimes anywhere
    function automatic logic signed [COORD_W-1:0] near_coord(int lo, int span);
        if ($urandom_range(0, 9) < 8)
            return COORD_W'(lo + int'($urandom_range(0, span)));
        return COORD_W'($urandom());
    endfunction

    // stimulus
    initial begin
        logic signed [COORD_W-1:0] ux, uy, lx, ly;
        logic [PIX_CNT_W-1:0]      pw, pt;
        logic [COUNT_W-1:0]        lim;
        int                        n_items, r, wide, tall;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset tile: corners of the pixel range and points inside it
        sender_calm = 1'b1;
        push_pixel(0, 0);
        push_pixel(PIXEL_MAX, PIXEL_MAX);
        push_pixel(255, 255);
        push_pixel(128, 128);
        push_pixel(96, 160);
        drain();

        // zero iteration limit, plus a write to an index with no register
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
        write_reg(REG_ITER_LIMIT, '0);
        sender_calm = 1'b0;
        push_pixel(0, 0);
        push_pixel(PIXEL_MAX, 0);
        drain();

        // extreme corners, zero pixel counts, pixels far outside the tile
        set_tile(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, '0, '0, 16'd20);
        push_pixel(0, 0);
        push_pixel(1, 1);
        push_pixel(PIXEL_MAX, PIXEL_MAX);
        push_pixel(2, 3);
        drain();

        // reversed extremes, widest width count and a tall count of 4096, single iteration
        set_tile(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 13'h1fff, 13'd4096, 16'd1);
        push_pixel(0, 0);
        push_pixel(PIXEL_MAX, 0);
        push_pixel(0, PIXEL_MAX);
        drain();

        // largest limit: the origin never escapes, the far column escapes at once
        set_tile('0, '0, COORD_MAX, '0, 13'd16, 13'd16, 16'hffff);
        push_pixel(0, 0);
        push_pixel(15, 0);
        push_pixel(5, 0);
        drain();

        // random tiles
        while (pixels_sent < ITEM_GOAL) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                ux = near_coord(-5 * Q_ONE / 2, 3 * Q_ONE);
                lx = ux + COORD_W'($urandom_range(Q_ONE / 64, 3 * Q_ONE));
                uy = near_coord(-Q_ONE, 5 * Q_ONE / 2);
                ly = uy - COORD_W'($urandom_range(Q_ONE / 64, 2 * Q_ONE));
            end else begin
                ux = COORD_W'($urandom());
                uy = COORD_W'($urandom());
                lx = COORD_W'($urandom());
                ly = COORD_W'($urandom());
            end
            r = $urandom_range(0, 9);
            pw = (r < 7) ? PIX_CNT_W'($urandom_range(1, 32)) :
                 (r < 9) ? PIX_CNT_W'($urandom_range(33, 4096)) : PIX_CNT_W'($urandom());
            r = $urandom_range(0, 9);
            pt = (r < 7) ? PIX_CNT_W'($urandom_range(1, 32)) :
                 (r < 9) ? PIX_CNT_W'($urandom_range(33, 4096)) : PIX_CNT_W'($urandom());
            r = $urandom_range(0, 19);
            lim = (r < 14) ? COUNT_W'($urandom_range(1, 48)) :
                  (r < 19) ? COUNT_W'($urandom_range(49, 255)) :
                             COUNT_W'($urandom_range(256, 600));
            set_tile(ux, uy, lx, ly, pw, pt, lim);

            // pixels mostly inside the tile
            wide = (pw == 0) ? 1 : ((pw > PIXEL_MAX) ? PIXEL_MAX + 1 : int'(pw));
            tall = (pt == 0) ? 1 : ((pt > PIXEL_MAX) ? PIXEL_MAX + 1 : int'(pt));
            sender_calm = ($urandom_range(0, 4) == 0);
            n_items = $urandom_range(15, 50);
            repeat (n_items) begin
                if ($urandom_range(0, 4) != 0)
                    push_pixel($urandom_range(0, wide - 1), $urandom_range(0, tall - 1));
                else
                    push_pixel($urandom_range(0, PIXEL_MAX), $urandom_range(0, PIXEL_MAX));
            end
            drain();
        end

        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial begin
        #200_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: mandelbrot_escape_time_unit.f
rtl/core/met_pkg.sv
rtl/core/met_front.sv
rtl/core/met_queue.sv
rtl/core/met_iter.sv
rtl/core/mandelbrot_escape_time_unit.sv
rtl/core/met_checker.sv
bench/mandelbrot_escape_time_checker.sv
bench/mandelbrot_escape_time_unit_test.sv
